FILE: hdl/alil_pkg.sv
// shared types, codes and widths for the array list insert/delete block
package alil_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 7;
   localparam int TYPE_W    = 2;
   localparam int KIND_W    = 2;
   localparam int STAT_W    = 2;
   localparam int OP_W      = 2;
   localparam int Q_DEPTH   = 2;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_INSERT  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DELETE  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DISPLAY = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   // classified commands handed from front to back
   localparam logic [OP_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] CMD_DELETE  = 2'd1;
   localparam logic [OP_W-1:0] CMD_DISPLAY = 2'd2;
   localparam logic [OP_W-1:0] CMD_REPORT  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         moves;
      logic [CNT_W-1:0]         start;
      logic [CNT_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         len_now;
   } cmd_type;

endpackage

FILE: hdl/alil_front.sv
// front end: accepts requests, checks bounds, tracks length, issues commands
module alil_front #(
   parameter int DEPTH = alil_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [alil_pkg::TYPE_W-1:0]           req_type,
   input  logic signed [alil_pkg::DATA_W-1:0]    req_value,
   input  logic [alil_pkg::CNT_W-1:0]            req_position,
   input  logic                                  q_full,
   output logic                                  push,
   output alil_pkg::cmd_type                     push_cmd
);
   import alil_pkg::*;

   localparam int LW = $clog2(DEPTH + 1);

   logic [LW-1:0]    length_ff, length_in;
   logic [CNT_W-1:0] len_w;
   logic             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign len_w     = CNT_W'(length_ff);

   always_comb begin
      length_in        = length_ff;
      push             = 1'b0;
      push_cmd.op      = CMD_REPORT;
      push_cmd.status  = ST_OK;
      push_cmd.moves   = '0;
      push_cmd.start   = '0;
      push_cmd.pos     = req_position;
      push_cmd.value   = req_value;
      push_cmd.len_now = len_w;
      if (accept) begin
         case (req_type)
            REQ_INSERT: begin
               push = 1'b1;
               if (len_w == CNT_W'(DEPTH)) begin
                  push_cmd.status = ST_FULL;
               end else if (req_position > len_w) begin
                  push_cmd.status = ST_RANGE;
               end else begin
                  push_cmd.op      = CMD_INSERT;
                  push_cmd.moves   = len_w - req_position;
                  push_cmd.start   = len_w - CNT_W'(1);
                  push_cmd.len_now = len_w + CNT_W'(1);
                  length_in        = length_ff + LW'(1);
               end
            end
            REQ_DELETE: begin
               push = 1'b1;
               if (req_position >= len_w) begin
                  push_cmd.status = ST_RANGE;
               end else begin
                  push_cmd.op      = CMD_DELETE;
                  push_cmd.moves   = len_w - req_position - CNT_W'(1);
                  push_cmd.start   = req_position + CNT_W'(1);
                  push_cmd.len_now = len_w - CNT_W'(1);
                  length_in        = length_ff - LW'(1);
               end
            end
            REQ_DISPLAY: begin
               push        = 1'b1;
               push_cmd.op = CMD_DISPLAY;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

endmodule

FILE: hdl/alil_queue.sv
// short command queue between front end and back end
module alil_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  alil_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output alil_pkg::cmd_type q_cmd
);
   import alil_pkg::*;

   localparam int PW = $clog2(Q_DEPTH);
   localparam int NW = $clog2(Q_DEPTH + 1);

   cmd_type       entry_ff [Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full    = (count_ff == NW'(Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/alil_back.sv
// back end: list memory, sequential shifter and result register
module alil_back #(
   parameter int DEPTH = alil_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  alil_pkg::cmd_type                     q_cmd,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [alil_pkg::KIND_W-1:0]           rsp_kind,
   output logic [alil_pkg::STAT_W-1:0]           rsp_status,
   output logic [alil_pkg::CNT_W-1:0]            rsp_move_count,
   output logic signed [alil_pkg::DATA_W-1:0]    rsp_element,
   output logic [alil_pkg::CNT_W-1:0]            rsp_length_now,
   output logic                                  rsp_last
);
   import alil_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MOVE   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_WVAL   = 3'd3;
   localparam logic [2:0] S_REPORT = 3'd4;
   localparam logic [2:0] S_DISP   = 3'd5;

   logic [2:0]               state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [AW-1:0]            ra_ff, ra_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic                     wr_pend_ff, wr_pend_in;
   logic [AW-1:0]            wr_addr_ff, wr_addr_in;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_ff;
   logic [AW-1:0]            rd_addr;
   logic                     we;
   logic [AW-1:0]            waddr;
   logic signed [DATA_W-1:0] wdata;

   logic                     out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [CNT_W-1:0]         moves_ff, moves_in;
   logic signed [DATA_W-1:0] elem_ff, elem_in;
   logic [CNT_W-1:0]         len_ff, len_in;
   logic                     last_ff, last_in;
   logic                     load;
   logic                     slot_free;

   assign slot_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      ra_in      = ra_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      rd_ok_in   = 1'b0;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      rd_addr    = ra_ff;
      pop        = 1'b0;
      load       = 1'b0;
      kind_in    = KIND_MOVE;
      status_in  = cmd_ff.status;
      moves_in   = cmd_ff.moves;
      elem_in    = '0;
      len_in     = cmd_ff.len_now;
      last_in    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               ra_in  = q_cmd.start[AW-1:0];
               cnt_in = q_cmd.moves;
               idx_in = '0;
               case (q_cmd.op)
                  CMD_INSERT: begin
                     state_in = (q_cmd.moves != '0) ? S_MOVE : S_WVAL;
                  end
                  CMD_DELETE: begin
                     state_in = (q_cmd.moves != '0) ? S_MOVE : S_REPORT;
                  end
                  CMD_DISPLAY: begin
                     state_in = (q_cmd.len_now != '0) ? S_DISP : S_REPORT;
                  end
                  default: begin
                     state_in = S_REPORT;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // read one entry, write it one slot over on the next cycle
            rd_addr    = ra_ff;
            wr_pend_in = 1'b1;
            if (cmd_ff.op == CMD_INSERT) begin
               wr_addr_in = ra_ff + AW'(1);
               ra_in      = ra_ff - AW'(1);
            end else begin
               wr_addr_in = ra_ff - AW'(1);
               ra_in      = ra_ff + AW'(1);
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = (cmd_ff.op == CMD_INSERT) ? S_WVAL : S_REPORT;
         end
         S_WVAL: begin
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (slot_free) begin
               load     = 1'b1;
               kind_in  = (cmd_ff.op == CMD_DISPLAY) ? KIND_EMPTY : KIND_MOVE;
               state_in = S_IDLE;
            end
         end
         S_DISP: begin
            rd_addr = idx_ff[AW-1:0];
            if (rd_ok_ff && slot_free) begin
               load      = 1'b1;
               kind_in   = KIND_ELEM;
               status_in = ST_OK;
               moves_in  = '0;
               elem_in   = rd_ff;
               last_in   = (idx_ff + CNT_W'(1) == cmd_ff.len_now);
               idx_in    = idx_ff + CNT_W'(1);
               if (last_in) begin
                  state_in = S_IDLE;
               end
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // single write port: shifted entry or inserted value
   always_comb begin
      we    = wr_pend_ff || (state_ff == S_WVAL);
      waddr = (state_ff == S_WVAL) ? cmd_ff.pos[AW-1:0] : wr_addr_ff;
      wdata = (state_ff == S_WVAL) ? cmd_ff.value : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_ok_ff     <= 1'b0;
         wr_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ok_ff     <= rd_ok_in;
         wr_pend_ff   <= wr_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ra_ff      <= ra_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
      if (load) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         moves_ff  <= moves_in;
         elem_ff   <= elem_in;
         len_ff    <= len_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_status     = status_ff;
   assign rsp_move_count = moves_ff;
   assign rsp_element    = elem_ff;
   assign rsp_length_now = len_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: hdl/array_list_insert_delete.sv
// array list with positional insert/delete; the back end carries out one request at a time
// insert: m = entries moved up one slot, one move per cycle, then the value is written
// delete: m entries moved down one slot; rejected request or empty display: result only
// display of n entries: one result beat per entry, rsp_last marks the final beat
// a result stall holds the back end at its result; up to two commands queue between front and back
// synchronous active-high reset empties the list and the queue; ram contents are kept
module array_list_insert_delete #(
   parameter int DEPTH = alil_pkg::DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [alil_pkg::TYPE_W-1:0]           req_type,
   input  logic signed [alil_pkg::DATA_W-1:0]    req_value,
   input  logic [alil_pkg::CNT_W-1:0]            req_position,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [alil_pkg::KIND_W-1:0]           rsp_kind,
   output logic [alil_pkg::STAT_W-1:0]           rsp_status,
   output logic [alil_pkg::CNT_W-1:0]            rsp_move_count,
   output logic signed [alil_pkg::DATA_W-1:0]    rsp_element,
   output logic [alil_pkg::CNT_W-1:0]            rsp_length_now,
   output logic                                  rsp_last
);
   import alil_pkg::*;

   // front end to queue
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   // queue to back end
   logic    pop;
   logic    q_valid;
   cmd_type q_cmd;

   // front end keeps its own length copy, so bounds checks are settled at accept time
   alil_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_value    (req_value),
      .req_position (req_position),
      .q_full       (q_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   // command queue decouples acceptance from the slow shift and stream work
   alil_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   // back end owns the list ram and the result register
   alil_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_move_count (rsp_move_count),
      .rsp_element    (rsp_element),
      .rsp_length_now (rsp_length_now),
      .rsp_last       (rsp_last)
   );

endmodule
